/* sv/cpc_pkg.sv */
// Shared types, codes and constants for the CIGAR position cursor block.
package cpc_pkg;

    localparam int MAX_OPS_DEF = 64;

    localparam int POS_W    = 31;
    localparam int REF_W    = 32;
    localparam int LEN_W    = 28;
    localparam int CODE_W   = 4;
    localparam int INDEL_W  = 29;
    localparam int WORD_W   = LEN_W + CODE_W;

    typedef enum logic [1:0] {
        ITEM_START  = 2'd0,
        ITEM_APPEND = 2'd1,
        ITEM_QUERY  = 2'd2,
        ITEM_NONE   = 2'd3
    } t_item;

    localparam logic [CODE_W-1:0] OPC_M = 4'd0;
    localparam logic [CODE_W-1:0] OPC_I = 4'd1;
    localparam logic [CODE_W-1:0] OPC_D = 4'd2;
    localparam logic [CODE_W-1:0] OPC_N = 4'd3;
    localparam logic [CODE_W-1:0] OPC_S = 4'd4;
    localparam logic [CODE_W-1:0] OPC_H = 4'd5;
    localparam logic [CODE_W-1:0] OPC_X = 4'd8;

    localparam logic [1:0] ST_NONE   = 2'd0;
    localparam logic [1:0] ST_FOUND  = 2'd1;
    localparam logic [1:0] ST_INSIDE = 2'd2;

    typedef struct packed {
        logic               done;
        logic [1:0]         status;
        logic [LEN_W-1:0]   offs;
        logic [LEN_W-1:0]   read_index;
        logic [INDEL_W-1:0] indel;
        logic [REF_W-1:0]   next_ref;
        logic [LEN_W-1:0]   next_read;
        logic               is_ins;
    } t_eval_res;

endpackage

/* sv/cigar_position_cursor_core.sv */
// Top level of the CIGAR position cursor: operation store, cursor and walk control.
//
// Usage: an item is a transfer on the command channel, taken at a rising edge with
// i_start high and o_busy low. A start item sets the alignment start and empties the
// operation list; an append item stores one operation (appends beyond MAX_OPS are
// dropped). Neither produces a result, and both complete in the transfer cycle, so
// o_busy stays low and the next item may follow in the next cycle.
// A query item raises o_busy while the cursor walks the stored operations, one
// operation per cycle from the operation store, whose registered read port sets
// that pace. A query holds o_busy until the walk ends; its result is registered and
// appears on the o_ ports, with o_valid high for one cycle, as o_busy falls. The
// next item may be taken in the cycle in which the result is shown. Queries in
// sorted order move the cursor past only a few operations each.
// The receiver cannot stall, so results are never held. Reset empties the list and
// clears the cursor; the operation store needs no clearing pass.
module cigar_position_cursor_core #(
    parameter int MAX_OPS = cpc_pkg::MAX_OPS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [1:0]                        i_operation,
    input  logic [cpc_pkg::POS_W-1:0]         i_position,
    input  logic [cpc_pkg::CODE_W-1:0]        i_op_code,
    input  logic [cpc_pkg::LEN_W-1:0]         i_op_length,
    output logic                              o_busy,
    output logic                              o_valid,
    output logic [1:0]                        o_status,
    output logic [cpc_pkg::LEN_W-1:0]         o_match_offset,
    output logic [cpc_pkg::LEN_W-1:0]         o_read_index,
    output logic signed [cpc_pkg::INDEL_W-1:0] o_indel_length
);

    localparam int AW = (MAX_OPS > 1) ? $clog2(MAX_OPS) : 1;
    localparam int CW = $clog2(MAX_OPS + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_OPS);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_WALK = 2'b10
    } t_state;

    logic [cpc_pkg::WORD_W-1:0] r_mem [MAX_OPS];
    logic [cpc_pkg::WORD_W-1:0] r_rd_data;

    t_state                     r_state, n_state;
    logic [CW-1:0]              r_op_count, n_op_count;
    logic [CW-1:0]              r_op_cursor, n_op_cursor;
    logic [cpc_pkg::REF_W-1:0]  r_ref_cursor, n_ref_cursor;
    logic [cpc_pkg::LEN_W-1:0]  r_read_cursor, n_read_cursor;
    logic                       r_prev_ins, n_prev_ins;
    logic [cpc_pkg::POS_W-1:0]  r_pos;
    logic                       r_valid, n_valid;
    logic [1:0]                 r_status, n_status;
    logic [cpc_pkg::LEN_W-1:0]  r_offs, n_offs;
    logic [cpc_pkg::LEN_W-1:0]  r_index, n_index;
    logic [cpc_pkg::INDEL_W-1:0] r_indel, n_indel;

    logic                       accept;
    logic                       wr_en;
    logic                       walk_ok;
    cpc_pkg::t_eval_res         eval_res;

    assign accept = i_start && (r_state == S_IDLE);
    assign wr_en  = accept && (i_operation == cpc_pkg::ITEM_APPEND) &&
                    (r_op_count < CNT_MAX);

    cpc_eval u_eval (
        .i_position    (r_pos),
        .i_ref_cursor  (r_ref_cursor),
        .i_read_cursor (r_read_cursor),
        .i_word        (r_rd_data),
        .i_prev_ins    (r_prev_ins),
        .o_res         (eval_res)
    );

    assign walk_ok = (r_ref_cursor <= {1'b0, r_pos}) && (r_op_cursor < r_op_count);

    always_comb begin
        n_state       = r_state;
        n_op_count    = r_op_count;
        n_op_cursor   = r_op_cursor;
        n_ref_cursor  = r_ref_cursor;
        n_read_cursor = r_read_cursor;
        n_prev_ins    = r_prev_ins;
        n_valid       = 1'b0;
        n_status      = r_status;
        n_offs        = r_offs;
        n_index       = r_index;
        n_indel       = r_indel;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_operation)
                        cpc_pkg::ITEM_START: begin
                            n_ref_cursor  = {1'b0, i_position};
                            n_read_cursor = '0;
                            n_op_cursor   = '0;
                            n_op_count    = '0;
                            n_prev_ins    = 1'b0;
                        end
                        cpc_pkg::ITEM_APPEND: begin
                            if (wr_en) begin
                                n_op_count = r_op_count + 1'b1;
                            end
                        end
                        cpc_pkg::ITEM_QUERY: begin
                            n_state = S_WALK;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_WALK: begin
                if (!walk_ok || eval_res.done) begin
                    n_state  = S_IDLE;
                    n_valid  = 1'b1;
                    n_status = cpc_pkg::ST_NONE;
                    n_offs   = '0;
                    n_index  = '0;
                    n_indel  = '0;
                    if (walk_ok && (eval_res.status != cpc_pkg::ST_NONE)) begin
                        n_status = eval_res.status;
                        n_offs   = eval_res.offs;
                        n_index  = eval_res.read_index;
                        n_indel  = eval_res.indel;
                    end
                end else begin
                    n_op_cursor   = r_op_cursor + 1'b1;
                    n_ref_cursor  = eval_res.next_ref;
                    n_read_cursor = eval_res.next_read;
                    n_prev_ins    = eval_res.is_ins;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_op_count[AW-1:0]] <= {i_op_length, i_op_code};
        end
        r_rd_data <= r_mem[n_op_cursor[AW-1:0]];
        if (accept) begin
            r_pos <= i_position;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_op_count    <= '0;
            r_op_cursor   <= '0;
            r_ref_cursor  <= '0;
            r_read_cursor <= '0;
            r_prev_ins    <= 1'b0;
            r_valid       <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_op_count    <= n_op_count;
            r_op_cursor   <= n_op_cursor;
            r_ref_cursor  <= n_ref_cursor;
            r_read_cursor <= n_read_cursor;
            r_prev_ins    <= n_prev_ins;
            r_valid       <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_offs   <= n_offs;
        r_index  <= n_index;
        r_indel  <= n_indel;
    end

    assign o_busy         = (r_state != S_IDLE);
    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_match_offset = r_offs;
    assign o_read_index   = r_index;
    assign o_indel_length = $signed(r_indel);

endmodule

/* sv/cpc_eval.sv */
// Evaluates one stored CIGAR operation against the queried reference position.
module cpc_eval (
    input  logic [cpc_pkg::POS_W-1:0]  i_position,
    input  logic [cpc_pkg::REF_W-1:0]  i_ref_cursor,
    input  logic [cpc_pkg::LEN_W-1:0]  i_read_cursor,
    input  logic [cpc_pkg::WORD_W-1:0] i_word,
    input  logic                       i_prev_ins,
    output cpc_pkg::t_eval_res         o_res
);

    logic [cpc_pkg::CODE_W-1:0] code;
    logic [cpc_pkg::LEN_W-1:0]  len;
    logic [cpc_pkg::LEN_W-1:0]  inc;
    logic [cpc_pkg::REF_W:0]    pos_x;
    logic [cpc_pkg::REF_W:0]    run_end;
    logic [cpc_pkg::REF_W:0]    ref_sum;
    logic [cpc_pkg::LEN_W:0]    read_sum;
    logic [cpc_pkg::LEN_W:0]    idx_sum;
    logic [cpc_pkg::REF_W-1:0]  diff;
    logic                       at_pos;
    logic                       in_run;
    logic                       adv_ref;
    logic                       adv_read;

    assign code    = i_word[cpc_pkg::CODE_W-1:0];
    assign len     = i_word[cpc_pkg::WORD_W-1:cpc_pkg::CODE_W];
    assign pos_x   = {2'b00, i_position};
    assign run_end = {1'b0, i_ref_cursor} + {5'b00000, len};
    assign at_pos  = ({1'b0, i_ref_cursor} == pos_x);
    assign in_run  = (pos_x < run_end);
    assign diff    = {1'b0, i_position} - i_ref_cursor;

    always_comb begin
        o_res          = '0;
        inc            = len;
        adv_ref        = 1'b0;
        adv_read       = 1'b0;
        o_res.is_ins   = (code == cpc_pkg::OPC_I);
        case (code)
            cpc_pkg::OPC_X: begin
                inc = {{(cpc_pkg::LEN_W-1){1'b0}}, 1'b1};
                if (at_pos) begin
                    o_res.done   = 1'b1;
                    o_res.status = cpc_pkg::ST_FOUND;
                end else begin
                    adv_ref  = 1'b1;
                    adv_read = 1'b1;
                end
            end
            cpc_pkg::OPC_M: begin
                if (in_run) begin
                    o_res.done = 1'b1;
                    if (at_pos && i_prev_ins) begin
                        o_res.status = cpc_pkg::ST_NONE;
                    end else begin
                        o_res.status = cpc_pkg::ST_FOUND;
                        o_res.offs   = diff[cpc_pkg::LEN_W-1:0];
                    end
                end else begin
                    adv_ref  = 1'b1;
                    adv_read = 1'b1;
                end
            end
            cpc_pkg::OPC_D, cpc_pkg::OPC_N: begin
                if (at_pos) begin
                    o_res.done = 1'b1;
                    if (code == cpc_pkg::OPC_D) begin
                        o_res.status = cpc_pkg::ST_FOUND;
                        o_res.indel  = -{1'b0, len};
                    end
                end else if (in_run) begin
                    o_res.done   = 1'b1;
                    o_res.status = cpc_pkg::ST_INSIDE;
                end else begin
                    adv_ref = 1'b1;
                end
            end
            cpc_pkg::OPC_I: begin
                if (at_pos) begin
                    o_res.done   = 1'b1;
                    o_res.status = cpc_pkg::ST_FOUND;
                    o_res.indel  = {1'b0, len};
                end else begin
                    adv_read = 1'b1;
                end
            end
            cpc_pkg::OPC_S: begin
                adv_read = 1'b1;
            end
            default: begin
            end
        endcase
        ref_sum  = {1'b0, i_ref_cursor} + {5'b00000, inc};
        read_sum = {1'b0, i_read_cursor} + {1'b0, inc};
        idx_sum  = {1'b0, i_read_cursor} + {1'b0, o_res.offs};
        o_res.next_ref   = !adv_ref ? i_ref_cursor :
                           (ref_sum[cpc_pkg::REF_W] ? '1 : ref_sum[cpc_pkg::REF_W-1:0]);
        o_res.next_read  = !adv_read ? i_read_cursor :
                           (read_sum[cpc_pkg::LEN_W] ? '1 : read_sum[cpc_pkg::LEN_W-1:0]);
        o_res.read_index = idx_sum[cpc_pkg::LEN_W] ? '1 : idx_sum[cpc_pkg::LEN_W-1:0];
    end

endmodule

/* tb/tb_cigar_position_cursor_core.sv */
// Self-checking testbench for the CIGAR position cursor core with a built-in cursor predictor.
module tb_cigar_position_cursor_core;

    localparam int POS_W   = cpc_pkg::POS_W;
    localparam int REF_W   = cpc_pkg::REF_W;
    localparam int LEN_W   = cpc_pkg::LEN_W;
    localparam int CODE_W  = cpc_pkg::CODE_W;
    localparam int INDEL_W = cpc_pkg::INDEL_W;
    localparam int DEPTH = cpc_pkg::MAX_OPS_DEF;
    localparam int ITEMS_PER_PHASE = 450;
    localparam int NUM_PHASES = 4;
    localparam bit [LEN_W-1:0] LEN_TOP = '1;
    localparam longint unsigned POS_TOP = 64'h7FFF_FFFF;

    typedef struct {
        cpc_pkg::t_item     kind;
        bit [POS_W-1:0]     pos;
        bit [CODE_W-1:0]    code;
        bit [LEN_W-1:0]     len;
        bit                 hold;
    } t_cmd;

    typedef struct packed {
        bit [1:0]           status;
        bit [LEN_W-1:0]     offs;
        bit [LEN_W-1:0]     ridx;
        bit [INDEL_W-1:0]   indel;
    } t_hit;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_start;
    logic [1:0]                i_operation;
    logic [POS_W-1:0]          i_position;
    logic [CODE_W-1:0]         i_op_code;
    logic [LEN_W-1:0]          i_op_length;
    logic                      o_busy;
    logic                      o_valid;
    logic [1:0]                o_status;
    logic [LEN_W-1:0]          o_match_offset;
    logic [LEN_W-1:0]          o_read_index;
    logic signed [INDEL_W-1:0] o_indel_length;

    cigar_position_cursor_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .i_operation    (i_operation),
        .i_position     (i_position),
        .i_op_code      (i_op_code),
        .i_op_length    (i_op_length),
        .o_busy         (o_busy),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_match_offset (o_match_offset),
        .o_read_index   (o_read_index),
        .o_indel_length (o_indel_length)
    );

    t_cmd cmd_q[$];
    t_hit hits_due[$];
    t_cmd cur_cmd;
    t_hit want_hit;

    bit [CODE_W-1:0] code_mem [DEPTH];
    bit [LEN_W-1:0]  len_mem  [DEPTH];
    int unsigned     op_total;
    int unsigned     op_ptr;
    bit [REF_W-1:0]  ref_pos;
    bit [LEN_W-1:0]  read_pos;

    int idle_pct;
    bit hold_next;
    bit query_open;
    int n_gen;
    int n_queries;
    int n_checked;
    int n_errors;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("Timeout with %0d results still expected.", hits_due.size());
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic bit [REF_W-1:0] ref_plus(input bit [REF_W-1:0] a,
                                                input longint unsigned b);
        longint unsigned s;
        s = 64'(a) + b;
        return (s > 64'hFFFF_FFFF) ? '1 : s[REF_W-1:0];
    endfunction

    function automatic bit [LEN_W-1:0] read_plus(input bit [LEN_W-1:0] a,
                                                 input longint unsigned b);
        longint unsigned s;
        s = 64'(a) + b;
        return (s > 64'(LEN_TOP)) ? LEN_TOP : s[LEN_W-1:0];
    endfunction

    // Moves the cursor toward the queried position and returns what the block must report.
    function automatic t_hit locate_position(input bit [POS_W-1:0] qpos);
        t_hit              h;
        bit                stop;
        bit [CODE_W-1:0]   c;
        longint unsigned   len;
        longint unsigned   r;
        longint unsigned   pos;
        longint unsigned   offs;
        longint            indel;
        h = '0;
        stop = 1'b0;
        offs = 0;
        indel = 0;
        pos = 64'(qpos);
        while (!stop && 64'(ref_pos) <= pos && op_ptr < op_total) begin
            c = code_mem[op_ptr];
            len = 64'(len_mem[op_ptr]);
            r = 64'(ref_pos);
            case (c)
                cpc_pkg::OPC_X: begin
                    if (r == pos) begin
                        h.status = cpc_pkg::ST_FOUND;
                        stop = 1'b1;
                    end else begin
                        ref_pos = ref_plus(ref_pos, 1);
                        read_pos = read_plus(read_pos, 1);
                        op_ptr++;
                    end
                end
                cpc_pkg::OPC_M: begin
                    if (pos < r + len) begin
                        stop = 1'b1;
                        if (!(r == pos && op_ptr > 0 &&
                              code_mem[op_ptr-1] == cpc_pkg::OPC_I)) begin
                            h.status = cpc_pkg::ST_FOUND;
                            offs = pos - r;
                        end
                    end else begin
                        ref_pos = ref_plus(ref_pos, len);
                        read_pos = read_plus(read_pos, len);
                        op_ptr++;
                    end
                end
                cpc_pkg::OPC_D, cpc_pkg::OPC_N: begin
                    if (r == pos) begin
                        stop = 1'b1;
                        if (c == cpc_pkg::OPC_D) begin
                            h.status = cpc_pkg::ST_FOUND;
                            indel = -longint'(len);
                        end
                    end else if (r + len > pos) begin
                        stop = 1'b1;
                        h.status = cpc_pkg::ST_INSIDE;
                    end else begin
                        ref_pos = ref_plus(ref_pos, len);
                        op_ptr++;
                    end
                end
                cpc_pkg::OPC_I: begin
                    if (r == pos) begin
                        stop = 1'b1;
                        h.status = cpc_pkg::ST_FOUND;
                        indel = longint'(len);
                    end else begin
                        read_pos = read_plus(read_pos, len);
                        op_ptr++;
                    end
                end
                cpc_pkg::OPC_S: begin
                    read_pos = read_plus(read_pos, len);
                    op_ptr++;
                end
                default: begin
                    op_ptr++;
                end
            endcase
        end
        if (h.status != cpc_pkg::ST_NONE) begin
            h.offs = offs[LEN_W-1:0];
            h.ridx = read_plus(read_pos, offs);
            h.indel = indel[INDEL_W-1:0];
        end
        return h;
    endfunction

    function automatic void track_item(input t_cmd c);
        case (c.kind)
            cpc_pkg::ITEM_START: begin
                ref_pos = REF_W'(c.pos);
                read_pos = '0;
                op_ptr = 0;
                op_total = 0;
            end
            cpc_pkg::ITEM_APPEND: begin
                if (op_total < DEPTH) begin
                    code_mem[op_total] = c.code;
                    len_mem[op_total] = c.len;
                    op_total++;
                end
            end
            cpc_pkg::ITEM_QUERY: begin
                hits_due.push_back(locate_position(c.pos));
                n_queries++;
            end
            default: begin
            end
        endcase
    endfunction

    function automatic void push_cmd(input cpc_pkg::t_item kind, input bit [POS_W-1:0] pos,
                                     input bit [CODE_W-1:0] code, input bit [LEN_W-1:0] len);
        t_cmd c;
        c.kind = kind;
        c.pos = pos;
        c.code = code;
        c.len = len;
        c.hold = hold_next || ($urandom_range(199) == 0);
        hold_next = 1'b0;
        cmd_q.push_back(c);
        if (kind != cpc_pkg::ITEM_NONE)
            n_gen++;
    endfunction

    function automatic bit [POS_W-1:0] any_pos();
        return POS_W'($urandom);
    endfunction

    function automatic bit [CODE_W-1:0] any_code();
        return CODE_W'($urandom);
    endfunction

    function automatic bit [LEN_W-1:0] any_len();
        return LEN_W'($urandom);
    endfunction

    function automatic bit [CODE_W-1:0] random_code();
        int r;
        bit [CODE_W-1:0] c;
        r = $urandom_range(99);
        if (r < 38)      c = cpc_pkg::OPC_M;
        else if (r < 48) c = cpc_pkg::OPC_I;
        else if (r < 58) c = cpc_pkg::OPC_D;
        else if (r < 65) c = cpc_pkg::OPC_N;
        else if (r < 72) c = cpc_pkg::OPC_S;
        else if (r < 77) c = cpc_pkg::OPC_H;
        else if (r < 88) c = cpc_pkg::OPC_X;
        else begin
            c = CODE_W'($urandom_range(6, 15));
            if (c == cpc_pkg::OPC_X)
                c = CODE_W'($urandom_range(9, 15));
        end
        return c;
    endfunction

    function automatic bit [LEN_W-1:0] random_len();
        int r;
        r = $urandom_range(99);
        if (r < 85)
            return LEN_W'($urandom_range(1, 12));
        if (r < 92)
            return '0;
        return any_len();
    endfunction

    function automatic longint unsigned step_back(input longint unsigned q,
                                                  input longint unsigned d);
        return (q > d) ? q - d : 0;
    endfunction

    // A well-formed read: start, a handful of operations, then mostly sorted queries.
    function automatic void gen_normal_read();
        longint unsigned base;
        longint unsigned q;
        int nops;
        int nq;
        int r;
        if ($urandom_range(3) == 0)
            base = 64'($urandom) & POS_TOP;
        else
            base = 64'($urandom_range(0, 100000));
        push_cmd(cpc_pkg::ITEM_START, POS_W'(base), any_code(), any_len());
        nops = $urandom_range(1, 20);
        for (int i = 0; i < nops; i++)
            push_cmd(cpc_pkg::ITEM_APPEND, any_pos(), random_code(), random_len());
        q = step_back(base, 64'($urandom_range(0, 2)));
        nq = $urandom_range(3, 16);
        for (int i = 0; i < nq; i++) begin
            r = $urandom_range(99);
            if (r < 5)
                push_cmd(cpc_pkg::ITEM_QUERY, any_pos(), any_code(), any_len());
            else begin
                if (r < 12)
                    q = step_back(q, 64'($urandom_range(1, 5)));
                else if (r < 94)
                    q = q + 64'($urandom_range(0, 4));
                else
                    q = q + 64'($urandom_range(0, 4000));
                if (q > POS_TOP)
                    q = POS_TOP;
                push_cmd(cpc_pkg::ITEM_QUERY, POS_W'(q), any_code(), any_len());
            end
            if ($urandom_range(99) < 4)
                push_cmd(cpc_pkg::t_item'($urandom_range(1, 3)), any_pos(), random_code(),
                         random_len());
        end
    endfunction

    // More appends than the list holds, then queries at rising positions from the start.
    function automatic void gen_overfull_read();
        longint unsigned base;
        longint unsigned q;
        int nops;
        base = 64'($urandom_range(0, 5000));
        push_cmd(cpc_pkg::ITEM_START, POS_W'(base), any_code(), any_len());
        nops = DEPTH + int'($urandom_range(1, 8));
        for (int i = 0; i < nops; i++)
            push_cmd(cpc_pkg::ITEM_APPEND, any_pos(), random_code(),
                     LEN_W'($urandom_range(0, 8)));
        q = base;
        for (int i = 0; i < 14; i++) begin
            push_cmd(cpc_pkg::ITEM_QUERY, POS_W'(q), any_code(), any_len());
            q = q + 64'($urandom_range(0, 50));
        end
    endfunction

    // Full-length operations that saturate the read cursor and give the largest indels.
    function automatic void gen_saturating_read();
        longint unsigned base;
        longint unsigned top;
        base = 64'($urandom_range(0, 1000000));
        top = 64'(LEN_TOP);
        push_cmd(cpc_pkg::ITEM_START, POS_W'(base), any_code(), any_len());
        push_cmd(cpc_pkg::ITEM_APPEND, any_pos(), cpc_pkg::OPC_S, LEN_TOP);
        push_cmd(cpc_pkg::ITEM_APPEND, any_pos(), cpc_pkg::OPC_S, LEN_TOP);
        push_cmd(cpc_pkg::ITEM_APPEND, any_pos(), cpc_pkg::OPC_M, LEN_W'(10));
        push_cmd(cpc_pkg::ITEM_APPEND, any_pos(), cpc_pkg::OPC_D, LEN_TOP);
        push_cmd(cpc_pkg::ITEM_APPEND, any_pos(), cpc_pkg::OPC_I, LEN_TOP);
        push_cmd(cpc_pkg::ITEM_APPEND, any_pos(), cpc_pkg::OPC_M, LEN_W'(5));
        push_cmd(cpc_pkg::ITEM_QUERY, POS_W'(base), any_code(), any_len());
        push_cmd(cpc_pkg::ITEM_QUERY, POS_W'(base + 64'd4), any_code(), any_len());
        push_cmd(cpc_pkg::ITEM_QUERY, POS_W'(base + 64'd10), any_code(), any_len());
        push_cmd(cpc_pkg::ITEM_QUERY, POS_W'(base + 64'd11 + 64'($urandom_range(0, 1000))),
                 any_code(), any_len());
        push_cmd(cpc_pkg::ITEM_QUERY, POS_W'(base + 64'd10 + top), any_code(), any_len());
        push_cmd(cpc_pkg::ITEM_QUERY, POS_W'(base + 64'd11 + top), any_code(), any_len());
        push_cmd(cpc_pkg::ITEM_QUERY, POS_W'(base + 64'd10 + top), any_code(), any_len());
    endfunction

    // Driver: presents the next pending item once the current transfer has happened.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
            i_operation <= cpc_pkg::ITEM_NONE;
            i_position <= '0;
            i_op_code <= cpc_pkg::OPC_M;
            i_op_length <= '0;
            query_open = 1'b0;
        end else begin
            if (o_valid)
                query_open = 1'b0;
            if (i_start && !o_busy) begin
                track_item(cur_cmd);
                if (cur_cmd.kind == cpc_pkg::ITEM_QUERY)
                    query_open = 1'b1;
            end
            if (!i_start || !o_busy) begin
                if (cmd_q.size() != 0 && !(cmd_q[0].hold && query_open) &&
                    $urandom_range(99) >= idle_pct) begin
                    cur_cmd = cmd_q.pop_front();
                    i_start <= 1'b1;
                    i_operation <= cur_cmd.kind;
                    i_position <= cur_cmd.pos;
                    i_op_code <= cur_cmd.code;
                    i_op_length <= cur_cmd.len;
                end else begin
                    i_start <= 1'b0;
                end
            end
        end
    end

    task automatic flag_mismatch(input string msg);
        n_errors++;
        if (n_errors <= 10)
            $display("%0t: mismatch: %s", $time, msg);
    endtask

    // Monitor: every result strobe is checked against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (hits_due.size() == 0) begin
                flag_mismatch($sformatf("result with none expected, status %0d", o_status));
            end else begin
                want_hit = hits_due.pop_front();
                n_checked++;
                if (o_status !== want_hit.status)
                    flag_mismatch($sformatf("status expected %0d got %0d",
                                            want_hit.status, o_status));
                if (o_match_offset !== want_hit.offs)
                    flag_mismatch($sformatf("match_offset expected %0d got %0d",
                                            want_hit.offs, o_match_offset));
                if (o_read_index !== want_hit.ridx)
                    flag_mismatch($sformatf("read_index expected %0d got %0d",
                                            want_hit.ridx, o_read_index));
                if (o_indel_length !== want_hit.indel)
                    flag_mismatch($sformatf("indel_length expected %0d got %0d",
                                            $signed(want_hit.indel), o_indel_length));
            end
        end
    end

    initial begin
        int phase_idle [NUM_PHASES];
        int target;
        int pick;
        int n_noise;
        phase_idle = '{0, 54, 0, 8};
        i_rst_n = 1'b0;
        idle_pct = 0;
        hold_next = 1'b0;
        n_gen = 0;
        n_queries = 0;
        n_checked = 0;
        n_errors = 0;
        op_total = 0;
        op_ptr = 0;
        ref_pos = '0;
        read_pos = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Query on an empty list, then an ignored item with every field at its top value.
        push_cmd(cpc_pkg::ITEM_QUERY, '0, '0, '0);
        push_cmd(cpc_pkg::ITEM_NONE, '1, '1, '1);
        // Read at 100: 5S 10M 3I 4M 2D 3N 7X 2H, an unknown code, then 5M.
        push_cmd(cpc_pkg::ITEM_START, POS_W'(100), '0, '0);
        push_cmd(cpc_pkg::ITEM_APPEND, '0, cpc_pkg::OPC_S, LEN_W'(5));
        push_cmd(cpc_pkg::ITEM_APPEND, '0, cpc_pkg::OPC_M, LEN_W'(10));
        push_cmd(cpc_pkg::ITEM_APPEND, '0, cpc_pkg::OPC_I, LEN_W'(3));
        push_cmd(cpc_pkg::ITEM_APPEND, '0, cpc_pkg::OPC_M, LEN_W'(4));
        push_cmd(cpc_pkg::ITEM_APPEND, '0, cpc_pkg::OPC_D, LEN_W'(2));
        push_cmd(cpc_pkg::ITEM_APPEND, '0, cpc_pkg::OPC_N, LEN_W'(3));
        push_cmd(cpc_pkg::ITEM_APPEND, '0, cpc_pkg::OPC_X, LEN_W'(7));
        push_cmd(cpc_pkg::ITEM_APPEND, '0, cpc_pkg::OPC_H, LEN_W'(2));
        push_cmd(cpc_pkg::ITEM_APPEND, '1, '1, LEN_TOP);
        push_cmd(cpc_pkg::ITEM_APPEND, '0, cpc_pkg::OPC_M, LEN_W'(5));
        push_cmd(cpc_pkg::ITEM_QUERY, POS_W'(100), '0, '0);
        push_cmd(cpc_pkg::ITEM_QUERY, POS_W'(110), '0, '0);
        push_cmd(cpc_pkg::ITEM_QUERY, POS_W'(111), '0, '0);
        push_cmd(cpc_pkg::ITEM_QUERY, POS_W'(110), '0, '0);
        push_cmd(cpc_pkg::ITEM_QUERY, POS_W'(114), '0, '0);
        push_cmd(cpc_pkg::ITEM_QUERY, POS_W'(115), '0, '0);
        push_cmd(cpc_pkg::ITEM_QUERY, POS_W'(116), '0, '0);
        push_cmd(cpc_pkg::ITEM_QUERY, POS_W'(119), '0, '0);
        push_cmd(cpc_pkg::ITEM_QUERY, POS_W'(122), '0, '0);
        push_cmd(cpc_pkg::ITEM_QUERY, POS_W'(200), '0, '0);
        push_cmd(cpc_pkg::ITEM_QUERY, POS_W'(50), '0, '0);

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            idle_pct = phase_idle[phase];
            hold_next = 1'b1;
            target = n_gen + ITEMS_PER_PHASE;
            while (n_gen < target) begin
                pick = $urandom_range(99);
                if (pick < 80)
                    gen_normal_read();
                else if (pick < 86)
                    gen_overfull_read();
                else if (pick < 91)
                    gen_saturating_read();
                else begin
                    n_noise = $urandom_range(1, 6);
                    for (int i = 0; i < n_noise; i++)
                        push_cmd(cpc_pkg::t_item'($urandom_range(0, 3)), any_pos(),
                                 any_code(), any_len());
                end
            end
            while (cmd_q.size() != 0 || i_start)
                @(posedge i_clk);
        end

        for (int w = 0; w < 2000 && hits_due.size() != 0; w++)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);

        $display("Run covered %0d items with %0d queries over %0d idling phases.",
                 n_gen, n_queries, NUM_PHASES);
        $display("%0d results checked, %0d mismatches, %0d results never arrived.",
                 n_checked, n_errors, hits_due.size());
        if (n_errors == 0 && hits_due.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
